/* src/ggds_pkg.sv */
// Package for the greedy global dominating set unit.
// Holds sizes, request codes and the cell control struct; no dependencies.
package ggds_pkg;
    localparam int VERTEX_LIMIT  = 64;
    localparam int FRACTION_BITS = 16;
    localparam int VIDX_W  = $clog2(VERTEX_LIMIT);
    localparam int VCNT_W  = $clog2(VERTEX_LIMIT + 1);
    localparam int NUMV_W  = 7;
    localparam int TOTAL_W = 7;
    localparam int SCORE_W = VCNT_W;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_STEP    = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    typedef logic [VERTEX_LIMIT-1:0] vmask_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic   wr_en;        // write row into the addressed cell
        logic   [VIDX_W-1:0] wr_idx;
        logic   score_en;     // clear the uncovered-vertex counts before a scan
        logic   shift_en;     // count passing covered bits; the top shifts the masks one place
        logic   prune_en;     // evaluate drop condition
        vmask_t vm;           // vertices in use
        vmask_t cov;          // current covered mask (for pruning)
        vmask_t ccov;
    } cell_ctl_t;
endpackage

/* src/ggds_cell.sv */
// One vertex cell: holds one adjacency row and counts uncovered neighbours and
// non-neighbours one bit per cycle as the covered masks pass by. Depends on ggds_pkg.
module ggds_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ggds_pkg::VIDX_W-1:0]   my_idx,
    input  ggds_pkg::cell_ctl_t           ctl,
    input  logic [63:0]                   row_in,
    input  logic                          cov_bit,   // covered bit for vertex j passing
    input  logic                          ccov_bit,
    input  logic [ggds_pkg::VIDX_W-1:0]   pos_j,     // vertex index j of passing bits
    output logic [63:0]                   row,
    output logic [ggds_pkg::SCORE_W-1:0]  score,
    output logic                          drop
);
    logic [63:0] row_reg;
    logic [ggds_pkg::SCORE_W-1:0] a_reg, a_next, b_reg, b_next;
    logic gb, cb;
    ggds_pkg::vmask_t self, g, c;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && ctl.wr_idx == my_idx)
        begin
            row_reg <= row_in;
        end
    end

    always_comb
    begin
        gb = row_reg[pos_j] && ctl.vm[pos_j] && (pos_j != my_idx);
        cb = !row_reg[pos_j] && ctl.vm[pos_j] && (pos_j != my_idx);
        a_next = a_reg;
        b_next = b_reg;
        if (ctl.score_en)
        begin
            a_next = '0;
            b_next = '0;
        end
        else if (ctl.shift_en)
        begin
            a_next = a_reg + ggds_pkg::SCORE_W'(gb && !cov_bit);
            b_next = b_reg + ggds_pkg::SCORE_W'(cb && !ccov_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    always_comb
    begin
        self = ggds_pkg::vmask_t'(1) << my_idx;
        g = row_reg & ctl.vm & ~self;
        c = ~row_reg & ctl.vm & ~self;
        drop = ctl.prune_en && ctl.cov[my_idx] && ctl.ccov[my_idx]
             && ((g & ~ctl.cov) == '0) && ((c & ~ctl.ccov) == '0);
    end

    assign row   = row_reg;
    assign score = (a_reg < b_reg) ? a_reg : b_reg;
endmodule

/* src/greedy_global_dominating_set_unit.sv */
// Top level of the greedy global dominating set unit.
// Instantiates the row of vertex cells; depends on ggds_pkg and ggds_cell.
//
// Usage: items enter on in_valid/in_stall carrying req_type, row_index,
// row_bits and rand_fraction. Every item gives exactly one result item on
// out_valid/out_stall. A row write, a restart, an undefined request or a
// rejected step goes from S_IDLE to S_OUT, which then raises out_valid.
// A step item runs a scan in which the covered masks shift past the
// cells, each cell counting its uncovered neighbours and non-neighbours
// one bit a cycle, then a walk over VERTEX_LIMIT cells that finds the
// best score and counts its ties, a second walk that picks the tie, then
// a state for coverage, one for pruning and one to load the result. The
// walks always run over every slot, whatever the vertex count, as one
// shared compare unit visits one cell a cycle.
// The block works on one item at a time; in_stall is high while busy or
// while a result waits. When the receiver stalls, the result is held in
// the output register and the block takes no new item until it is taken.
// Reset clears coverage, makes every vertex a candidate, sets the vertex
// count to 64 and clears the pick total. Adjacency rows are not cleared
// and must be written before use. num_vertices is written with cfg_we.
module greedy_global_dominating_set_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [5:0]  row_index,
    input  logic [63:0] row_bits,
    input  logic [15:0] rand_fraction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  pick_vertex,
    output logic [6:0]  chosen_count,
    output logic        all_covered,
    output logic        rejected
);
    localparam int N  = ggds_pkg::VERTEX_LIMIT;
    localparam int IW = ggds_pkg::VIDX_W;
    localparam int SW = ggds_pkg::SCORE_W;
    localparam int CW = ggds_pkg::VCNT_W;
    localparam int FB = ggds_pkg::FRACTION_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_BEST  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_PRUNE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [6:0] numv_reg;
    ggds_pkg::vmask_t cov_reg, ccov_reg, cand_reg, rot_c_reg, rot_cc_reg;
    logic [6:0] total_reg;
    logic [IW:0] cnt_reg;              // walk counter, one wider to compare with a vertex count of N
    logic [SW-1:0] best_reg;
    logic          found_reg;
    logic [CW-1:0] ties_reg, pos_reg;
    logic [IW-1:0] pick_reg;
    logic [15:0] frac_reg;
    logic [5:0]  o_vtx_reg;
    logic [6:0]  o_cnt_reg;
    logic        o_all_reg, o_rej_reg;

    // Vertices in use: zero acts as one, above the maximum acts as the maximum.
    logic [IW:0] nuse;
    ggds_pkg::vmask_t vm;
    always_comb
    begin
        if (numv_reg == 7'd0)
            nuse = (IW+1)'(1);
        else if (numv_reg > 7'(N))
            nuse = (IW+1)'(N);
        else
            nuse = (IW+1)'(numv_reg);
        vm = '0;
        for (int i = 0; i < N; i++)
            vm[i] = (i < int'(nuse));
    end

    logic done_now;
    assign done_now = ((cov_reg & vm) == vm) && ((ccov_reg & vm) == vm);

    ggds_pkg::cell_ctl_t ctl;
    logic [63:0] rows [N];
    logic [SW-1:0] scores [N];
    ggds_pkg::vmask_t drops;
    logic [IW-1:0] jpos;
    assign jpos = cnt_reg[IW-1:0];

    always_comb
    begin
        ctl.wr_en    = (state_reg == S_IDLE) && in_valid && !in_stall
                       && req_type == ggds_pkg::REQ_WRITE;
        ctl.wr_idx   = row_index[IW-1:0];
        ctl.score_en = (state_reg == S_IDLE);
        ctl.shift_en = (state_reg == S_SCAN);
        ctl.prune_en = (state_reg == S_PRUNE);
        ctl.vm       = vm;
        ctl.cov      = cov_reg;
        ctl.ccov     = ccov_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            ggds_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .my_idx   (IW'(gi)),
                .ctl      (ctl),
                .row_in   (row_bits),
                .cov_bit  (rot_c_reg[0]),
                .ccov_bit (rot_cc_reg[0]),
                .pos_j    (jpos),
                .row      (rows[gi]),
                .score    (scores[gi]),
                .drop     (drops[gi])
            );
        end
    endgenerate

    // Shared walk unit: looks at the cell addressed by the counter.
    logic [SW-1:0] cur_score;
    logic          cur_ok;
    assign cur_score = scores[jpos];
    assign cur_ok    = (cnt_reg < nuse) && cand_reg[jpos];

    logic [CW+FB-1:0] prod;
    assign prod = CW'(ties_reg) * FB'(frac_reg);

    ggds_pkg::vmask_t pbit, prow_g, prow_c;
    always_comb
    begin
        pbit   = ggds_pkg::vmask_t'(1) << pick_reg;
        prow_g = rows[pick_reg] & vm & ~pbit;
        prow_c = ~rows[pick_reg] & vm & ~pbit;
    end

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = (req_type == ggds_pkg::REQ_STEP && !done_now)
                                              ? S_SCAN : S_OUT;
            S_SCAN:  if (cnt_reg == (IW+1)'(N-1)) state_next = S_BEST;
            S_BEST:  if (cnt_reg == (IW+1)'(N-1)) state_next = found_reg || cur_ok
                                                               ? S_PICK : S_OUT;
            S_PICK:  if (cnt_reg == (IW+1)'(N-1)) state_next = S_APPLY;
            S_APPLY: state_next = S_PRUNE;
            S_PRUNE: state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            numv_reg  <= 7'd64;
            cov_reg   <= '0;
            ccov_reg  <= '0;
            cand_reg  <= '1;
            total_reg <= '0;
            cnt_reg   <= '0;
            out_valid <= 1'b0;
            found_reg <= 1'b0;
            o_vtx_reg <= '0;
            o_cnt_reg <= '0;
            o_all_reg <= 1'b0;
            o_rej_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                numv_reg <= cfg_wdata;
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg    <= '0;
                    found_reg  <= 1'b0;
                    ties_reg   <= '0;
                    rot_c_reg  <= cov_reg;
                    rot_cc_reg <= ccov_reg;
                    frac_reg   <= rand_fraction;
                    // The result fields of a waiting item stay put until a new
                    // item is accepted.
                    if (accept)
                    begin
                        o_vtx_reg <= '0;
                        o_rej_reg <= (req_type == ggds_pkg::REQ_STEP) && done_now;
                        if (req_type == ggds_pkg::REQ_RESTART)
                        begin
                            cov_reg   <= '0;
                            ccov_reg  <= '0;
                            cand_reg  <= '1;
                            total_reg <= '0;
                        end
                    end
                end
                S_SCAN:
                begin
                    rot_c_reg  <= rot_c_reg >> 1;
                    rot_cc_reg <= rot_cc_reg >> 1;
                    cnt_reg    <= (cnt_reg == (IW+1)'(N-1)) ? '0 : cnt_reg + 1'b1;
                end
                S_BEST:
                begin
                    if (cur_ok)
                    begin
                        if (!found_reg || cur_score > best_reg)
                        begin
                            best_reg <= cur_score;
                            ties_reg <= CW'(1);
                        end
                        else if (cur_score == best_reg)
                            ties_reg <= ties_reg + 1'b1;
                        found_reg <= 1'b1;
                    end
                    cnt_reg <= (cnt_reg == (IW+1)'(N-1)) ? '0 : cnt_reg + 1'b1;
                    pos_reg <= '1;
                end
                S_PICK:
                begin
                    if (cnt_reg == '0)
                        pos_reg <= (CW'(prod >> FB) >= ties_reg) ? ties_reg - 1'b1
                                                                  : CW'(prod >> FB);
                    if (cur_ok && cur_score == best_reg)
                    begin
                        if ((cnt_reg == '0 ? ((CW'(prod >> FB) >= ties_reg)
                                ? ties_reg - 1'b1 : CW'(prod >> FB)) : pos_reg) == '0)
                            pick_reg <= jpos;
                        if (cnt_reg != '0)
                            pos_reg <= pos_reg - 1'b1;
                        else
                            pos_reg <= ((CW'(prod >> FB) >= ties_reg) ? ties_reg - 1'b1
                                        : CW'(prod >> FB)) - 1'b1;
                    end
                    cnt_reg <= (cnt_reg == (IW+1)'(N-1)) ? '0 : cnt_reg + 1'b1;
                end
                S_APPLY:
                begin
                    cov_reg   <= cov_reg | pbit | prow_g;
                    ccov_reg  <= ccov_reg | pbit | prow_c;
                    cand_reg  <= cand_reg & ~pbit;
                    o_vtx_reg <= 6'(pick_reg);
                    if (total_reg != 7'd127)
                        total_reg <= total_reg + 1'b1;
                end
                S_PRUNE:
                    cand_reg <= cand_reg & ~(drops & vm);
                S_OUT:
                begin
                    out_valid <= 1'b1;
                    o_cnt_reg <= total_reg;
                    o_all_reg <= done_now;
                end
                default: ;
            endcase
        end
    end

    assign pick_vertex   = o_vtx_reg;
    assign chosen_count  = o_cnt_reg;
    assign all_covered   = o_all_reg;
    assign rejected      = o_rej_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item accepted while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pick_vertex)
                                      && $stable(chosen_count)))
        else $error("stalled result changed");
    a_pick_clears_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> !cand_reg[$past(pick_reg)])
        else $error("picked vertex still a candidate");
endmodule

/* test/greedy_global_dominating_set_unit_test.sv */
// Self-checking testbench for the greedy global dominating set unit.
// Depends on ggds_pkg and greedy_global_dominating_set_unit; holds its own
// software predictor of the greedy picks and a small result scoreboard.
module greedy_global_dominating_set_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 500;

    typedef struct packed {
        logic [5:0] vertex;
        logic [6:0] total;
        logic       covered;
        logic       rejected;
    } pick_result_t;

    // Scoreboard: the predictor's own copy of the unit's state, plus the
    // queue of results that are still to arrive.
    class pick_scoreboard;
        logic [63:0]  rows [ggds_pkg::VERTEX_LIMIT];
        logic [63:0]  cov, ccov, cand;
        logic [6:0]   total;
        logic [6:0]   vcount;
        pick_result_t pending[$];
        int           errors;

        function new();
            cov = '0; ccov = '0; cand = '1; total = '0; vcount = 7'd64;
            errors = 0;
            foreach (rows[i]) rows[i] = '0;
        endfunction

        function int used_n();
            if (vcount < 1) return 1;
            if (vcount > ggds_pkg::VERTEX_LIMIT) return ggds_pkg::VERTEX_LIMIT;
            return vcount;
        endfunction

        function logic [63:0] used_bits();
            int n;
            n = used_n();
            if (n >= 64) return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        function logic [63:0] nbr(int v, logic [63:0] vm);
            return rows[v] & vm & ~(64'd1 << v);
        endfunction

        function logic [63:0] cnbr(int v, logic [63:0] vm);
            return ~rows[v] & vm & ~(64'd1 << v);
        endfunction

        function bit finished(logic [63:0] vm);
            return ((cov & vm) == vm) && ((ccov & vm) == vm);
        endfunction

        // Note an accepted input item and queue the result it must cause.
        function void note_item(logic [1:0] req, logic [5:0] idx, logic [63:0] bits,
                                logic [15:0] frac);
            logic [63:0]  vm, ties;
            int           n, best, a, b, s, cnt, pos, pick;
            pick_result_t r;
            vm = used_bits();
            n = used_n();
            r = '0;
            if (req == ggds_pkg::REQ_WRITE) begin
                rows[idx] = bits;
            end else if (req == ggds_pkg::REQ_RESTART) begin
                cov = '0; ccov = '0; cand = '1; total = '0;
            end else if (req == ggds_pkg::REQ_STEP) begin
                if (finished(vm)) begin
                    r.rejected = 1'b1;
                end else begin
                    best = -1;
                    ties = '0;
                    for (int v = 0; v < n; v++) begin
                        if (!cand[v]) continue;
                        a = $countones(nbr(v, vm) & ~cov);
                        b = $countones(cnbr(v, vm) & ~ccov);
                        s = (a < b) ? a : b;
                        if (s > best) begin
                            best = s;
                            ties = '0;
                        end
                        if (s == best) ties[v] = 1'b1;
                    end
                    if (best >= 0) begin
                        cnt = $countones(ties);
                        pos = (cnt * int'(frac)) >> ggds_pkg::FRACTION_BITS;
                        if (pos >= cnt) pos = cnt - 1;
                        pick = 0;
                        for (int v = 0; v < n; v++) begin
                            if (ties[v]) begin
                                if (pos == 0) begin
                                    pick = v;
                                    break;
                                end
                                pos--;
                            end
                        end
                        cov  |= (64'd1 << pick) | nbr(pick, vm);
                        ccov |= (64'd1 << pick) | cnbr(pick, vm);
                        cand[pick] = 1'b0;
                        for (int v = 0; v < n; v++) begin
                            if (cand[v] && cov[v] && ccov[v] &&
                                (nbr(v, vm) & ~cov) == 0 && (cnbr(v, vm) & ~ccov) == 0)
                                cand[v] = 1'b0;
                        end
                        if (total < 7'd127) total++;
                        r.vertex = pick[5:0];
                    end
                end
            end
            r.total = total;
            r.covered = finished(vm);
            pending.push_back(r);
        endfunction

        function void check_result(pick_result_t got);
            pick_result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("result differs: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [5:0]  row_index = '0;
    logic [63:0] row_bits = '0;
    logic [15:0] rand_fraction = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  pick_vertex;
    logic [6:0]  chosen_count;
    logic        all_covered;
    logic        rejected;

    pick_scoreboard board = new();
    int  idle_cycles = 0;
    int  items_sent = 0;

    greedy_global_dominating_set_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .rand_fraction (rand_fraction),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pick_vertex   (pick_vertex),
        .chosen_count  (chosen_count),
        .all_covered   (all_covered),
        .rejected      (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results are sampled at the rising edge; the predictor is updated at the
    // same edge as the input is accepted, which always precedes its result.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                board.note_item(req_type, row_index, row_bits, rand_fraction);
            if (out_valid && !out_stall)
                board.check_result({pick_vertex, chosen_count, all_covered, rejected});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver draws a stall length for every result item.
    initial
    begin
        int gap;
        forever begin
            @(negedge clk);
            if (out_valid) begin
                gap = $urandom_range(0, 13);
                out_stall <= (gap != 0);
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("greedy_global_dominating_set_unit: mismatch");
            $finish;
        end
    end

    // Drive one item after a random gap and hold it until the unit takes it.
    task automatic send_item(input logic [1:0] req, input logic [5:0] idx,
                             input logic [63:0] bits, input logic [15:0] frac);
        int gap;
        gap = $urandom_range(0, 13);
        repeat (gap) @(negedge clk);
        in_valid      <= 1'b1;
        req_type      <= req;
        row_index     <= idx;
        row_bits      <= bits;
        rand_fraction <= frac;
        do @(posedge clk); while (in_stall);
        items_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
        req_type <= 2'($urandom_range(0, 3));
        row_bits <= {$urandom, $urandom};
    endtask

    // Register writes only happen once every result is back and the unit has
    // had time to settle.
    task automatic write_vertex_count(input logic [6:0] value);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.vcount = value;
    endtask

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // Load a fresh graph of n vertices (symmetric, edge density chosen per
    // graph), then restart; every row in use is written before any step.
    task automatic load_graph(input int n, input int density);
        logic [63:0] adj [ggds_pkg::VERTEX_LIMIT];
        foreach (adj[i]) adj[i] = '0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if ($urandom_range(0, 99) < density) begin
                    adj[i][j] = 1'b1;
                    adj[j][i] = 1'b1;
                end
        for (int i = 0; i < ggds_pkg::VERTEX_LIMIT; i++)
            if (i < n || $urandom_range(0, 7) == 0)
                send_item(ggds_pkg::REQ_WRITE, i[5:0],
                          adj[i] | (wide_random() & ~((64'd1 << n) - 1) & {64{n < 64}}),
                          16'($urandom));
        send_item(ggds_pkg::REQ_RESTART, 6'($urandom), wide_random(), 16'($urandom));
    endtask

    task automatic run_steps(input int count);
        for (int k = 0; k < count; k++)
            send_item(ggds_pkg::REQ_STEP, 6'($urandom), wide_random(), 16'($urandom));
    endtask

    initial
    begin
        int n;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: all 64 rows full, extreme fractions, self loops,
        // an undefined request and steps after completion.
        for (int i = 0; i < ggds_pkg::VERTEX_LIMIT; i++)
            send_item(ggds_pkg::REQ_WRITE, i[5:0], '1, '0);
        send_item(ggds_pkg::REQ_RESTART, '0, '0, '0);
        send_item(ggds_pkg::REQ_STEP, '1, '1, 16'hFFFF);
        send_item(ggds_pkg::REQ_STEP, '0, '0, 16'h0000);
        send_item(ggds_pkg::REQ_UNUSED, '1, '1, '1);
        send_item(ggds_pkg::REQ_STEP, '0, '0, 16'h8000);
        write_vertex_count(7'd1);
        send_item(ggds_pkg::REQ_RESTART, '0, '0, '0);
        run_steps(2);
        write_vertex_count(7'd0);
        send_item(ggds_pkg::REQ_RESTART, '0, '0, '0);
        run_steps(2);
        write_vertex_count(7'd127);
        send_item(ggds_pkg::REQ_WRITE, 6'd0, 64'h5555_5555_5555_5555, '0);
        send_item(ggds_pkg::REQ_RESTART, '0, '0, '0);
        run_steps(4);

        // Random part: mostly well-formed graphs given a run of steps, with some
        // noise items and restarts mixed in.
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       n = 64;
                1:       n = $urandom_range(1, 3);
                default: n = $urandom_range(2, 12);
            endcase
            write_vertex_count(n[6:0]);
            load_graph(n, $urandom_range(0, 100));
            for (int k = 0; k < n + 2 && k < 8; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(ggds_pkg::REQ_UNUSED, 6'($urandom), wide_random(),
                              16'($urandom));
                else
                    send_item(ggds_pkg::REQ_STEP, 6'($urandom), wide_random(),
                              16'($urandom));
            end
            if ($urandom_range(0, 4) == 0) begin
                send_item(ggds_pkg::REQ_RESTART, 6'($urandom), wide_random(),
                          16'($urandom));
                run_steps(2);
            end
        end

        while (board.pending.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("greedy_global_dominating_set_unit: match");
        else
            $display("greedy_global_dominating_set_unit: mismatch");
        $finish;
    end
endmodule
